@@ rtl/frl_pkg.sv @@
// Shared types and constants for the fixed-window rate limiter.
`default_nettype none

package frl_pkg;

   localparam int unsigned CLIENT_BITS = 8;
   localparam int unsigned CLIENTS     = 1 << CLIENT_BITS;
   localparam int unsigned TIME_BITS   = 32;
   localparam int unsigned CFG_BITS    = 16;
   localparam int unsigned COUNT_BITS  = 17;
   localparam int unsigned CSR_IDX_BITS = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET = CFG_BITS'(60);
   localparam logic [CFG_BITS-1:0] REQUEST_LIMIT_RESET = CFG_BITS'(100);

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_LENGTH = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_REQUEST_LIMIT = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mem_read;
      logic eval;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/frl_ctrl.sv @@
// Controller state machine that sequences one transaction through the datapath.
`default_nettype none

module frl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire frl_pkg::dp_status_type status,
   output frl_pkg::dp_cmd_type        cmd
);

   frl_pkg::state_type state_ff;
   frl_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frl_pkg::ST_IDLE: begin
            if (req_valid) state_in = frl_pkg::ST_READ;
         end
         frl_pkg::ST_READ: begin
            state_in = frl_pkg::ST_EVAL;
         end
         frl_pkg::ST_EVAL: begin
            state_in = frl_pkg::ST_COMMIT;
         end
         frl_pkg::ST_COMMIT: begin
            if (status.out_free) state_in = frl_pkg::ST_IDLE;
         end
         default: begin
            state_in = frl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         frl_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         frl_pkg::ST_READ: begin
            cmd.mem_read = 1'b1;
         end
         frl_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         frl_pkg::ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/frl_dp.sv @@
// Datapath: configuration registers, client table, window arithmetic and result register.
`default_nettype none

module frl_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [frl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [frl_pkg::CFG_BITS-1:0]        csr_wdata,
   input  wire logic [frl_pkg::CLIENT_BITS-1:0]     req_client_index,
   input  wire logic [frl_pkg::TIME_BITS-1:0]       req_now_seconds,
   input  wire frl_pkg::dp_cmd_type                 cmd,
   output frl_pkg::dp_status_type                   status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_allowed,
   output logic [frl_pkg::CFG_BITS-1:0]             rsp_remaining,
   output logic [frl_pkg::TIME_BITS:0]              rsp_reset_time,
   output logic [frl_pkg::CFG_BITS-1:0]             rsp_wait_seconds
);

   localparam int unsigned TB = frl_pkg::TIME_BITS;
   localparam int unsigned CB = frl_pkg::COUNT_BITS;
   localparam int unsigned FB = frl_pkg::CFG_BITS;
   localparam int unsigned EB = TB + CB;

   logic [FB-1:0] window_length_ff;
   logic [FB-1:0] request_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= frl_pkg::WINDOW_LENGTH_RESET;
         request_limit_ff <= frl_pkg::REQUEST_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            frl_pkg::CSR_WINDOW_LENGTH: window_length_ff <= csr_wdata;
            frl_pkg::CSR_REQUEST_LIMIT: request_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Captured request.
   logic [frl_pkg::CLIENT_BITS-1:0] slot_ff;
   logic [TB-1:0]                   now_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff <= req_client_index;
         now_ff  <= req_now_seconds;
      end
   end

   // Client table: window start in the upper bits, count in the lower bits.
   logic [EB-1:0]              table_mem [frl_pkg::CLIENTS];
   logic [frl_pkg::CLIENTS-1:0] entry_valid_ff;
   logic [EB-1:0]              rd_data_ff;
   logic                       rd_valid_ff;
   logic [TB-1:0]              commit_start;
   logic [CB-1:0]              commit_count;

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_data_ff  <= table_mem[slot_ff];
         rd_valid_ff <= entry_valid_ff[slot_ff];
      end
      if (cmd.commit) begin
         table_mem[slot_ff] <= {commit_start, commit_count};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (cmd.commit) begin
         entry_valid_ff[slot_ff] <= 1'b1;
      end
   end

   // Evaluate stage: elapsed time, new-window decision, saturating increment.
   logic [TB-1:0] start_rd;
   logic [CB-1:0] count_rd;
   logic [TB-1:0] elapsed_in;
   logic          new_window_in;
   logic [CB-1:0] count_inc_in;
   logic [TB-1:0] start_ff;
   logic [FB-1:0] elapsed_ff;
   logic          new_window_ff;
   logic [CB-1:0] count_inc_ff;

   always_comb begin
      start_rd      = rd_valid_ff ? rd_data_ff[EB-1:CB] : '0;
      count_rd      = rd_valid_ff ? rd_data_ff[CB-1:0] : '0;
      elapsed_in    = (now_ff >= start_rd) ? (now_ff - start_rd) : '0;
      new_window_in = (start_rd == '0) ||
                      (elapsed_in >= {{(TB-FB){1'b0}}, window_length_ff});
      count_inc_in  = (count_rd == frl_pkg::COUNT_MAX) ? frl_pkg::COUNT_MAX
                                                       : count_rd + frl_pkg::COUNT_ONE;
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         start_ff      <= start_rd;
         elapsed_ff    <= elapsed_in[FB-1:0];
         new_window_ff <= new_window_in;
         count_inc_ff  <= count_inc_in;
      end
   end

   // Commit stage: table update and result.
   logic [FB-1:0] elapsed_eff;
   logic          allowed_in;
   logic [FB-1:0] remaining_in;
   logic [TB:0]   reset_time_in;
   logic [FB-1:0] wait_seconds_in;

   always_comb begin
      commit_start    = new_window_ff ? now_ff : start_ff;
      commit_count    = new_window_ff ? frl_pkg::COUNT_ONE : count_inc_ff;
      // Without a new window the elapsed time is below the window length.
      elapsed_eff     = new_window_ff ? '0 : elapsed_ff;
      allowed_in      = commit_count <= {{(CB-FB){1'b0}}, request_limit_ff};
      remaining_in    = allowed_in ? (request_limit_ff - commit_count[FB-1:0]) : '0;
      reset_time_in   = allowed_in ? ({1'b0, commit_start} + {{(TB+1-FB){1'b0}},
                                      window_length_ff}) : '0;
      wait_seconds_in = allowed_in ? '0 : (window_length_ff - elapsed_eff);
   end

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          allowed_ff;
   logic [FB-1:0] remaining_ff;
   logic [TB:0]   reset_time_ff;
   logic [FB-1:0] wait_seconds_ff;

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         allowed_ff      <= allowed_in;
         remaining_ff    <= remaining_in;
         reset_time_ff   <= reset_time_in;
         wait_seconds_ff <= wait_seconds_in;
      end
   end

   assign status.out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allowed      = allowed_ff;
   assign rsp_remaining    = remaining_ff;
   assign rsp_reset_time   = reset_time_ff;
   assign rsp_wait_seconds = wait_seconds_ff;

endmodule

`default_nettype wire

@@ rtl/fixed_window_rate_limiter_core.sv @@
// Top level of the fixed-window rate limiter: controller, datapath and checks.
`default_nettype none

// Each request transaction names a client slot and the current time, and produces one
// response transaction that says whether the request is allowed, how many requests remain
// in the window and when it resets, or, when denied, how many seconds to wait. A response
// becomes valid after its request passes the table read, the window evaluation and the
// table update with the result load, in that order, set by the read-modify-write of the
// single-port client table; a new request can be accepted in the cycle after the previous
// response is loaded, and the commit waits while an earlier response has not been taken.
// The client table reads as zero after reset through per-entry valid bits, so no clearing
// pass is needed.
module fixed_window_rate_limiter_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [frl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [frl_pkg::CFG_BITS-1:0]        csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [frl_pkg::CLIENT_BITS-1:0]     req_client_index,
   input  wire logic [frl_pkg::TIME_BITS-1:0]       req_now_seconds,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_allowed,
   output logic [frl_pkg::CFG_BITS-1:0]             rsp_remaining,
   output logic [frl_pkg::TIME_BITS:0]              rsp_reset_time,
   output logic [frl_pkg::CFG_BITS-1:0]             rsp_wait_seconds
);

   frl_pkg::dp_cmd_type    cmd;
   frl_pkg::dp_status_type status;

   frl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   frl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_client_index (req_client_index),
      .req_now_seconds  (req_now_seconds),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_allowed      (rsp_allowed),
      .rsp_remaining    (rsp_remaining),
      .rsp_reset_time   (rsp_reset_time),
      .rsp_wait_seconds (rsp_wait_seconds)
   );

   a_denied_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_allowed |-> rsp_remaining == '0 && rsp_reset_time == '0)
      else $error("denied response carries remaining or reset time");

   a_allowed_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_allowed |-> rsp_wait_seconds == '0)
      else $error("allowed response carries retry time");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a transaction is in progress");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a transaction in progress");

endmodule

`default_nettype wire
